// ----- rtl/kci_pkg.sv -----
// ----------------------------------------------------------------------------
// kci_pkg
// Shared types, codes and constants of the keyframe channel interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

   // Default sizes
   localparam int KCI_MAX_KEYS     = 256;
   localparam int KCI_NUM_CHANNELS = 31;

   // Command codes of the input word
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_START      = 3'd1;
   localparam logic [2:0] CMD_STOP       = 3'd2;
   localparam logic [2:0] CMD_LOAD_TIME  = 3'd3;
   localparam logic [2:0] CMD_LOAD_VALUE = 3'd4;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_POLL_INTERVAL    = 2'd0,
      CSR_KEYFRAME_COUNT   = 2'd1,
      CSR_SPEECH_END_TIME  = 2'd2,
      CSR_SPEECH_END_VALID = 2'd3
   } csr_index_type;

   // Time and value constants (Q16.16 times, Q4.12 values)
   localparam logic [32:0]        END_PAD    = 33'd3277;
   localparam logic [32:0]        REST_CLOSE = 33'd19661;
   localparam logic [32:0]        REST_STOP  = 33'd32768;
   localparam logic signed [15:0] JAW_NEAR   = 16'sd205;
   localparam logic signed [15:0] JAW_SHUT   = 16'sd82;
   localparam int                 JAW_CH     = 1;
   localparam logic [31:0]        POLL_RESET = 32'd65536;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [19:0]        delta_time;
      logic [7:0]         key_index;
      logic [4:0]         channel_select;
      logic [31:0]        key_time_in;
      logic signed [15:0] key_value_in;
   } req_word_type;

   typedef struct packed {
      logic [4:0]         channel_id;
      logic signed [15:0] channel_value;
      logic               last_channel;
      logic               poll_request;
      logic               is_animating;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_last;
      logic end_chk;
      logic srch_rd;
      logic srch_chk;
      logic t0_rd;
      logic t1_rd;
      logic jaw_rd;
      logic rest_chk;
      logic blend_set;
      logic div_step;
      logic ease1;
      logic ease2;
      logic lerp_rdc;
      logic lerp_rdn;
      logic lerp_mul;
      logic lerp_add;
      logic out_take;
      logic zero_all;
      logic stop_finish;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic anim_go;
      logic end_hit;
      logic srch_hit;
      logic srch_last;
      logic rest_zero;
      logic rest_stop;
      logic den_zero;
      logic need_div;
      logic div_done;
      logic ch_last;
      logic out_last;
   } dp_status_type;

endpackage

// ----- rtl/kci_ram.sv -----
// ----------------------------------------------------------------------------
// kci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kci_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/kci_ctrl.sv -----
// ----------------------------------------------------------------------------
// kci_ctrl
// Sequencer of one command: search, blend, divide, ease, lerp, then output.
// ----------------------------------------------------------------------------
module kci_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [2:0]             req_cmd,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  kci_pkg::dp_status_type status,
   output kci_pkg::ctrl_cmd_type  cmd
);
   import kci_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE     = 18'h00001,
      ST_END_RD   = 18'h00002,
      ST_END_CHK  = 18'h00004,
      ST_SRCH_RD  = 18'h00008,
      ST_SRCH_CHK = 18'h00010,
      ST_T0_RD    = 18'h00020,
      ST_T1_RD    = 18'h00040,
      ST_JAW_RD   = 18'h00080,
      ST_REST_CHK = 18'h00100,
      ST_BLEND    = 18'h00200,
      ST_DIV      = 18'h00400,
      ST_EASE1    = 18'h00800,
      ST_EASE2    = 18'h01000,
      ST_L_RDC    = 18'h02000,
      ST_L_RDN    = 18'h04000,
      ST_L_MUL    = 18'h08000,
      ST_L_ADD    = 18'h10000,
      ST_OUT      = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_cmd == CMD_TICK) begin
                  state_in = status.anim_go ? ST_END_RD : ST_OUT;
               end
            end
         end
         ST_END_RD: begin
            cmd.rd_last = 1'b1;
            state_in    = ST_END_CHK;
         end
         ST_END_CHK: begin
            cmd.end_chk = 1'b1;
            if (status.end_hit) begin
               cmd.stop_finish = 1'b1;
               state_in        = ST_OUT;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            cmd.srch_rd = 1'b1;
            state_in    = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            cmd.srch_chk = 1'b1;
            state_in = (status.srch_hit || status.srch_last) ? ST_T0_RD : ST_SRCH_RD;
         end
         ST_T0_RD: begin
            cmd.t0_rd = 1'b1;
            state_in  = ST_T1_RD;
         end
         ST_T1_RD: begin
            cmd.t1_rd = 1'b1;
            state_in  = ST_JAW_RD;
         end
         ST_JAW_RD: begin
            cmd.jaw_rd = 1'b1;
            state_in   = ST_REST_CHK;
         end
         ST_REST_CHK: begin
            cmd.rest_chk = 1'b1;
            if (status.rest_zero) begin
               cmd.zero_all    = 1'b1;
               cmd.stop_finish = status.rest_stop;
               state_in        = ST_OUT;
            end else begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            cmd.blend_set = 1'b1;
            priority if (status.den_zero) begin
               state_in = ST_L_RDC;
            end else if (status.need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_EASE1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EASE1;
            end
         end
         ST_EASE1: begin
            cmd.ease1 = 1'b1;
            state_in  = ST_EASE2;
         end
         ST_EASE2: begin
            cmd.ease2 = 1'b1;
            state_in  = ST_L_RDC;
         end
         ST_L_RDC: begin
            cmd.lerp_rdc = 1'b1;
            state_in     = ST_L_RDN;
         end
         ST_L_RDN: begin
            cmd.lerp_rdn = 1'b1;
            state_in     = ST_L_MUL;
         end
         ST_L_MUL: begin
            cmd.lerp_mul = 1'b1;
            state_in     = ST_L_ADD;
         end
         ST_L_ADD: begin
            cmd.lerp_add = 1'b1;
            state_in     = status.ch_last ? ST_OUT : ST_L_RDC;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cmd.out_take = 1'b1;
               if (status.out_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/kci_dp.sv -----
// ----------------------------------------------------------------------------
// kci_dp
// Datapath: registers, keyframe memories, search, divider, easing and lerp.
// ----------------------------------------------------------------------------
module kci_dp #(
   parameter int MAX_KEYS     = kci_pkg::KCI_MAX_KEYS,
   parameter int NUM_CHANNELS = kci_pkg::KCI_NUM_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kci_pkg::req_word_type  req_word,
   output kci_pkg::rsp_word_type  rsp_word,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  kci_pkg::ctrl_cmd_type  cmd,
   output kci_pkg::dp_status_type status
);
   import kci_pkg::*;

   localparam int KAW    = $clog2(MAX_KEYS);
   localparam int NW     = $clog2(MAX_KEYS + 1);
   localparam int VDEPTH = MAX_KEYS * NUM_CHANNELS;
   localparam int VAW    = $clog2(VDEPTH);
   localparam int CW     = $clog2(NUM_CHANNELS);

   // configuration
   logic [31:0] poll_interval_ff;
   logic [8:0]  keyframe_count_ff;
   logic [31:0] speech_end_time_ff;
   logic        speech_end_valid_ff;

   // playback state
   logic [31:0]        elapsed_ff, poll_timer_ff;
   logic               playing_ff, finished_ff, poll_ff;
   logic signed [15:0] cur_val_ff [NUM_CHANNELS];

   // working registers
   logic [KAW-1:0]     scan_ff, cur_ff, nxt_ff;
   logic [31:0]        last_ff, prev_ff, t0_ff, t1_ff;
   logic               rest_ff;
   logic [33:0]        rem_ff;
   logic [32:0]        dvs_ff;
   logic [15:0]        q_ff;
   logic [3:0]         div_cnt_ff;
   logic [16:0]        a_ff, sq_ff, bx_ff, alpha_ff;
   logic signed [15:0] c_ff;
   logic signed [34:0] lp_ff;
   logic [CW-1:0]      ch_ff, out_ch_ff;

   // memories
   logic [31:0]        kt_rdata;
   logic [15:0]        kv_rdata;
   logic [KAW-1:0]     kt_raddr;
   logic [VAW-1:0]     kv_raddr, kv_waddr;
   logic               kt_we, kv_we;

   // request decode
   logic        acc_tick, acc_start, acc_stop;
   logic [31:0] key_ext;
   logic        key_ok, ch_ok;
   logic [32:0] el_sum, pt_sum;
   logic [31:0] el_sat, pt_sat;
   logic        poll_hit, zero_now;

   assign acc_tick  = cmd.accept && (req_word.cmd == CMD_TICK);
   assign acc_start = cmd.accept && (req_word.cmd == CMD_START);
   assign acc_stop  = cmd.accept && (req_word.cmd == CMD_STOP);
   assign key_ext   = 32'(req_word.key_index);
   assign key_ok    = key_ext < 32'(MAX_KEYS);
   assign ch_ok     = 32'(req_word.channel_select) < 32'(NUM_CHANNELS);
   assign kt_we     = cmd.accept && (req_word.cmd == CMD_LOAD_TIME) && key_ok;
   assign kv_we     = cmd.accept && (req_word.cmd == CMD_LOAD_VALUE) && key_ok && ch_ok;
   assign kv_waddr  = VAW'(key_ext * 32'(NUM_CHANNELS) + 32'(req_word.channel_select));

   // saturating time updates
   assign el_sum   = {1'b0, elapsed_ff} + 33'(req_word.delta_time);
   assign el_sat   = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
   assign pt_sum   = {1'b0, poll_timer_ff} + 33'(req_word.delta_time);
   assign pt_sat   = pt_sum[32] ? 32'hFFFF_FFFF : pt_sum[31:0];
   assign poll_hit = !playing_ff && (pt_sat >= poll_interval_ff);

   // effective table length
   logic [NW-1:0]  n_w;
   logic [KAW-1:0] last_idx;
   assign n_w = (32'(keyframe_count_ff) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS)
                                                         : NW'(keyframe_count_ff);
   assign last_idx = KAW'(n_w - NW'(1));

   // read address selection
   always_comb begin
      priority if (cmd.rd_last) begin
         kt_raddr = last_idx;
      end else if (cmd.t0_rd) begin
         kt_raddr = cur_ff;
      end else if (cmd.t1_rd) begin
         kt_raddr = nxt_ff;
      end else begin
         kt_raddr = scan_ff;
      end
   end

   always_comb begin
      priority if (cmd.jaw_rd) begin
         kv_raddr = VAW'(32'(cur_ff) * 32'(NUM_CHANNELS) + 32'(JAW_CH));
      end else if (cmd.lerp_rdn) begin
         kv_raddr = VAW'(32'(nxt_ff) * 32'(NUM_CHANNELS) + 32'(ch_ff));
      end else begin
         kv_raddr = VAW'(32'(cur_ff) * 32'(NUM_CHANNELS) + 32'(ch_ff));
      end
   end

   kci_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_key_times (
      .clock   (clock),
      .wr_en   (kt_we),
      .wr_addr (KAW'(key_ext)),
      .wr_data (req_word.key_time_in),
      .rd_addr (kt_raddr),
      .rd_data (kt_rdata)
   );

   kci_ram #(.WIDTH(16), .DEPTH(VDEPTH)) u_key_values (
      .clock   (clock),
      .wr_en   (kv_we),
      .wr_addr (kv_waddr),
      .wr_data (req_word.key_value_in),
      .rd_addr (kv_raddr),
      .rd_data (kv_rdata)
   );

   // search and rest-phase checks
   logic               srch_hit;
   logic signed [15:0] jaw;
   logic               rest_w;
   assign srch_hit = (scan_ff != '0) && (elapsed_ff >= prev_ff) && (elapsed_ff < kt_rdata);
   assign jaw      = $signed(kv_rdata);
   assign rest_w   = speech_end_valid_ff && (elapsed_ff >= speech_end_time_ff) &&
                     (jaw < JAW_NEAR);

   // blend setup
   logic signed [33:0] num_w, den_w, num_a, den_a;
   logic               den_zero, num_le, num_ge;
   assign num_w    = $signed({2'b00, elapsed_ff}) - $signed({2'b00, t0_ff});
   assign den_w    = $signed({2'b00, t1_ff}) - $signed({2'b00, t0_ff});
   assign num_a    = den_w[33] ? -num_w : num_w;
   assign den_a    = den_w[33] ? -den_w : den_w;
   assign den_zero = (den_w == '0);
   assign num_le   = (num_a <= 34'sd0);
   assign num_ge   = (num_a >= den_a);

   // restoring divider step
   logic [33:0] div_sh;
   logic        div_ge;
   assign div_sh = {rem_ff[32:0], 1'b0};
   assign div_ge = div_sh >= {1'b0, dvs_ff};

   // easing
   logic [16:0] ease_x;
   logic [33:0] ease_sq;
   logic [17:0] ease_f;
   logic [34:0] ease_p;
   logic [18:0] ease_r;
   logic [16:0] ease_out;
   assign ease_x  = rest_ff ? 17'(17'h10000 - a_ff) : a_ff;
   assign ease_sq = 34'(ease_x) * 34'(ease_x) + 34'd32768;
   assign ease_f  = rest_ff ? {1'b0, bx_ff} : 18'(18'h30000 - {a_ff, 1'b0});
   assign ease_p  = 35'(sq_ff) * 35'(ease_f) + 35'd32768;
   assign ease_r  = ease_p[34:16];
   always_comb begin
      if (rest_ff) begin
         ease_out = (ease_r > 19'd65536) ? 17'd0 : 17'(19'd65536 - ease_r);
      end else begin
         ease_out = (ease_r > 19'd65536) ? 17'h10000 : ease_r[16:0];
      end
   end

   // lerp
   logic signed [16:0] lerp_d;
   logic signed [34:0] lerp_p, lerp_s;
   logic signed [18:0] lerp_r;
   logic signed [19:0] lerp_v;
   logic signed [15:0] lerp_q;
   assign lerp_d = 17'($signed(kv_rdata)) - 17'(c_ff);
   assign lerp_p = 35'(lerp_d) * 35'($signed({1'b0, alpha_ff}));
   assign lerp_s = lp_ff + 35'sd32768;
   assign lerp_r = lerp_s[34:16];
   assign lerp_v = 20'(c_ff) + 20'(lerp_r);
   always_comb begin
      priority if (lerp_v > 20'sd32767) begin
         lerp_q = 16'sh7FFF;
      end else if (lerp_v < -20'sd32768) begin
         lerp_q = -16'sh8000;
      end else begin
         lerp_q = lerp_v[15:0];
      end
   end

   assign zero_now = acc_stop || cmd.zero_all || cmd.stop_finish ||
                     (acc_tick && !finished_ff && !(playing_ff && keyframe_count_ff != '0));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff    <= POLL_RESET;
         keyframe_count_ff   <= '0;
         speech_end_time_ff  <= '0;
         speech_end_valid_ff <= 1'b0;
         elapsed_ff          <= '0;
         poll_timer_ff       <= '0;
         playing_ff          <= 1'b0;
         finished_ff         <= 1'b0;
         poll_ff             <= 1'b0;
         out_ch_ff           <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cur_val_ff[i] <= '0;
         end
      end else begin
         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_POLL_INTERVAL:    poll_interval_ff    <= csr_data;
               CSR_KEYFRAME_COUNT:   keyframe_count_ff   <= csr_data[8:0];
               CSR_SPEECH_END_TIME:  speech_end_time_ff  <= csr_data;
               CSR_SPEECH_END_VALID: speech_end_valid_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (acc_start) begin
            elapsed_ff  <= '0;
            playing_ff  <= 1'b1;
            finished_ff <= 1'b0;
         end
         if (acc_stop) begin
            playing_ff <= 1'b0;
         end
         // tick front end
         if (acc_tick) begin
            out_ch_ff <= '0;
            if (finished_ff) begin
               poll_ff     <= 1'b1;
               finished_ff <= 1'b0;
            end else begin
               elapsed_ff <= el_sat;
               poll_ff    <= poll_hit;
               if (!playing_ff) begin
                  poll_timer_ff <= poll_hit ? 32'd0 : pt_sat;
               end
            end
         end
         if (cmd.stop_finish) begin
            playing_ff  <= 1'b0;
            finished_ff <= 1'b1;
         end
         if (cmd.out_take) begin
            out_ch_ff <= out_ch_ff + CW'(1);
         end
         // channel values
         if (zero_now) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               cur_val_ff[i] <= '0;
            end
         end else if (cmd.lerp_add) begin
            cur_val_ff[ch_ff] <= lerp_q;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.end_chk) begin
         last_ff <= kt_rdata;
         scan_ff <= '0;
      end
      if (cmd.srch_chk) begin
         prev_ff <= kt_rdata;
         scan_ff <= scan_ff + KAW'(1);
         priority if (srch_hit) begin
            cur_ff <= scan_ff - KAW'(1);
            nxt_ff <= scan_ff;
         end else if (scan_ff == last_idx) begin
            nxt_ff <= (elapsed_ff >= last_ff) ? last_idx
                    : ((n_w > NW'(1)) ? KAW'(1) : KAW'(0));
            cur_ff <= ((elapsed_ff >= last_ff) && (n_w >= NW'(2))) ? KAW'(n_w - NW'(2))
                    : KAW'(0);
         end else begin
         end
      end
      if (cmd.t1_rd) begin
         t0_ff <= kt_rdata;
      end
      if (cmd.jaw_rd) begin
         t1_ff <= kt_rdata;
      end
      if (cmd.rest_chk) begin
         rest_ff <= rest_w;
      end
      if (cmd.blend_set) begin
         ch_ff      <= '0;
         div_cnt_ff <= '0;
         q_ff       <= '0;
         rem_ff     <= num_a[33:0];
         dvs_ff     <= den_a[32:0];
         alpha_ff   <= '0;
         a_ff       <= num_le ? 17'd0 : 17'h10000;
      end
      if (cmd.div_step) begin
         rem_ff     <= div_ge ? (div_sh - {1'b0, dvs_ff}) : div_sh;
         q_ff       <= {q_ff[14:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 4'd1;
         a_ff       <= {1'b0, q_ff[14:0], div_ge};
      end
      if (cmd.ease1) begin
         sq_ff <= ease_sq[32:16];
         bx_ff <= ease_x;
      end
      if (cmd.ease2) begin
         alpha_ff <= ease_out;
      end
      if (cmd.lerp_rdn) begin
         c_ff <= $signed(kv_rdata);
      end
      if (cmd.lerp_mul) begin
         lp_ff <= lerp_p;
      end
      if (cmd.lerp_add) begin
         ch_ff <= ch_ff + CW'(1);
      end
   end

   // status
   always_comb begin
      status           = '0;
      status.anim_go   = !finished_ff && playing_ff && (keyframe_count_ff != '0);
      status.end_hit   = {1'b0, elapsed_ff} > ({1'b0, kt_rdata} + END_PAD);
      status.srch_hit  = srch_hit;
      status.srch_last = (scan_ff == last_idx);
      status.rest_zero = rest_w && (jaw < JAW_SHUT) &&
                         ({1'b0, elapsed_ff} > ({1'b0, speech_end_time_ff} + REST_CLOSE));
      status.rest_stop = {1'b0, elapsed_ff} > ({1'b0, speech_end_time_ff} + REST_STOP);
      status.den_zero  = den_zero;
      status.need_div  = !den_zero && !num_le && !num_ge;
      status.div_done  = (div_cnt_ff == 4'd15);
      status.ch_last   = (ch_ff == CW'(NUM_CHANNELS - 1));
      status.out_last  = (out_ch_ff == CW'(NUM_CHANNELS - 1));
   end

   // result word
   always_comb begin
      rsp_word.channel_id    = 5'(out_ch_ff);
      rsp_word.channel_value = cur_val_ff[out_ch_ff];
      rsp_word.last_channel  = (out_ch_ff == CW'(NUM_CHANNELS - 1));
      rsp_word.poll_request  = poll_ff;
      rsp_word.is_animating  = playing_ff;
   end
endmodule

// ----- rtl/keyframe_channel_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_channel_interpolator
// Keyframe table playback with eased linear blend of every channel per tick.
// ----------------------------------------------------------------------------
//  channel | ports               | direction | word
//  req     | req_valid/req_ready | in        | command, delta time, load data
//  rsp     | rsp_valid/rsp_ready | out       | one channel value per word
//  csr     | csr_valid/csr_ready | in        | register index and data
//
//  A playing tick reads the last key time, searches over the single key time
//  RAM port, reads the bracketing key times and the jaw value, runs the
//  radix-2 divider when needed, eases, lerps every channel through the key
//  value RAM port, then sends NUM_CHANNELS words. Idle ticks go straight to
//  output. Reset is synchronous; no clearing pass. rsp stalls hold the block.
// ----------------------------------------------------------------------------
module keyframe_channel_interpolator #(
   parameter int MAX_KEYS     = kci_pkg::KCI_MAX_KEYS,
   parameter int NUM_CHANNELS = kci_pkg::KCI_NUM_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kci_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kci_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import kci_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   kci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_word.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kci_dp #(.MAX_KEYS(MAX_KEYS), .NUM_CHANNELS(NUM_CHANNELS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );
endmodule

// ----- dv/keyframe_channel_interpolator_checker.sv -----
// ----------------------------------------------------------------------------
// keyframe_channel_interpolator_checker
// Watches the req, rsp and csr channels of the interpolator, predicts every
// rsp word from accepted req words and register writes, and compares the
// words field by field in order.
// ----------------------------------------------------------------------------
module keyframe_channel_interpolator_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  kci_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  kci_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   output int                    fail_count,
   output int                    words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import kci_pkg::*;

   localparam int NK = KCI_MAX_KEYS;
   localparam int NC = KCI_NUM_CHANNELS;

   // Shadow registers
   logic [31:0] poll_interval_q;
   logic [8:0]  key_count_q;
   logic [31:0] speech_end_q;
   logic        speech_valid_q;

   // Shadow table and playback state
   logic [31:0]        key_time_tbl [NK];
   logic signed [15:0] key_val_tbl  [NK][NC];
   logic signed [15:0] chan_vals    [NC];
   logic [31:0]        elapsed_q;
   logic [31:0]        poll_timer_q;
   logic               playing_q;
   logic               finished_q;

   rsp_word_type channel_words_due [$];

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic longint unsigned round16(longint unsigned x);
      return (x + 64'd32768) >> 16;
   endfunction

   // Blend factor from the bracketing key times, eased
   function automatic logic [31:0] eased_alpha(logic [31:0] t0, logic [31:0] t1,
                                               logic [31:0] e, bit rest);
      longint num, den;
      longint unsigned a, b, b3, a2;
      num = $signed({32'd0, e}) - $signed({32'd0, t0});
      den = $signed({32'd0, t1}) - $signed({32'd0, t0});
      if (den == 0) return 32'd0;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num <= 0) a = 0;
      else if (num >= den) a = 65536;
      else a = (unsigned'(num) << 16) / unsigned'(den);
      if (rest) begin
         b  = 65536 - a;
         b3 = round16(round16(b * b) * b);
         a  = (b3 > 65536) ? 0 : 65536 - b3;
      end else begin
         a2 = round16(a * a);
         a  = round16(a2 * (196608 - 2 * a));
         if (a > 65536) a = 65536;
      end
      return a[31:0];
   endfunction

   function automatic logic signed [15:0] mix_channel(logic signed [15:0] c,
                                                      logic signed [15:0] n,
                                                      logic [31:0] alpha);
      longint p, v;
      p = (longint'(n) - longint'(c)) * $signed({32'd0, alpha}) + 32768;
      v = longint'(c) + (p >>> 16);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   task automatic clear_vals();
      foreach (chan_vals[i]) chan_vals[i] = '0;
   endtask

   task automatic halt_playback();
      playing_q  = 1'b0;
      finished_q = 1'b1;
      clear_vals();
   endtask

   // Key search, rest phase rules and channel blend
   task automatic animate_frame();
      int n, cur, nxt;
      bit hit, rest;
      logic signed [15:0] jaw;
      logic [31:0] alpha;
      n   = (key_count_q > NK) ? NK : key_count_q;
      hit = 0;
      cur = 0;
      nxt = 0;
      rest = 0;
      for (int i = 0; i + 1 < n; i++) begin
         if (!hit && elapsed_q >= key_time_tbl[i] && elapsed_q < key_time_tbl[i+1]) begin
            cur = i;
            nxt = i + 1;
            hit = 1;
         end
      end
      if (!hit) begin
         if (elapsed_q >= key_time_tbl[n-1]) begin
            cur = (n >= 2) ? n - 2 : 0;
            nxt = n - 1;
         end else begin
            cur = 0;
            nxt = (n > 1) ? 1 : 0;
         end
      end
      jaw = key_val_tbl[cur][JAW_CH];
      if (speech_valid_q && elapsed_q >= speech_end_q && jaw < JAW_NEAR) begin
         rest = 1;
         if (jaw < JAW_SHUT && {1'b0, elapsed_q} > {1'b0, speech_end_q} + REST_CLOSE) begin
            clear_vals();
            if ({1'b0, elapsed_q} > {1'b0, speech_end_q} + REST_STOP) halt_playback();
            return;
         end
      end
      alpha = eased_alpha(key_time_tbl[cur], key_time_tbl[nxt], elapsed_q, rest);
      for (int ch = 0; ch < NC; ch++)
         chan_vals[ch] = mix_channel(key_val_tbl[cur][ch], key_val_tbl[nxt][ch], alpha);
   endtask

   // One tick: time, poll, playback, then one word per channel
   task automatic frame_tick(logic [19:0] dt);
      bit poll;
      int n;
      rsp_word_type w;
      poll = 0;
      if (finished_q) begin
         poll = 1;
         finished_q = 1'b0;
      end else begin
         elapsed_q = sat_sum(elapsed_q, {12'd0, dt});
         if (!playing_q) begin
            poll_timer_q = sat_sum(poll_timer_q, {12'd0, dt});
            if (poll_timer_q >= poll_interval_q) begin
               poll = 1;
               poll_timer_q = '0;
            end
         end
         if (playing_q && key_count_q > 0) begin
            n = (key_count_q > NK) ? NK : key_count_q;
            if ({1'b0, elapsed_q} > {1'b0, key_time_tbl[n-1]} + END_PAD) halt_playback();
            else animate_frame();
         end else begin
            clear_vals();
         end
      end
      for (int k = 0; k < NC; k++) begin
         w.channel_id    = k[4:0];
         w.channel_value = chan_vals[k];
         w.last_channel  = (k == NC - 1);
         w.poll_request  = poll;
         w.is_animating  = playing_q;
         channel_words_due.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         poll_interval_q = POLL_RESET;
         key_count_q     = '0;
         speech_end_q    = '0;
         speech_valid_q  = 1'b0;
         clear_vals();
         elapsed_q    = '0;
         poll_timer_q = '0;
         playing_q    = 1'b0;
         finished_q   = 1'b0;
         fail_count   = 0;
         channel_words_due.delete();
      end else begin
         // Result side first: it always belongs to an earlier tick
         if (rsp_valid && rsp_ready) begin
            if (channel_words_due.size() == 0) begin
               $error("rsp word with nothing expected: %p", rsp_word);
               fail_count++;
            end else begin
               want = channel_words_due.pop_front();
               if (rsp_word.channel_id !== want.channel_id) begin
                  $error("channel_id expected %0d got %0d", want.channel_id,
                         rsp_word.channel_id);
                  fail_count++;
               end
               if (rsp_word.channel_value !== want.channel_value) begin
                  $error("channel_value expected %0d got %0d", want.channel_value,
                         rsp_word.channel_value);
                  fail_count++;
               end
               if (rsp_word.last_channel !== want.last_channel) begin
                  $error("last_channel expected %0b got %0b", want.last_channel,
                         rsp_word.last_channel);
                  fail_count++;
               end
               if (rsp_word.poll_request !== want.poll_request) begin
                  $error("poll_request expected %0b got %0b", want.poll_request,
                         rsp_word.poll_request);
                  fail_count++;
               end
               if (rsp_word.is_animating !== want.is_animating) begin
                  $error("is_animating expected %0b got %0b", want.is_animating,
                         rsp_word.is_animating);
                  fail_count++;
               end
            end
         end
         // Register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLL_INTERVAL:    poll_interval_q = csr_data;
               CSR_KEYFRAME_COUNT:   key_count_q     = csr_data[8:0];
               CSR_SPEECH_END_TIME:  speech_end_q    = csr_data;
               CSR_SPEECH_END_VALID: speech_valid_q  = csr_data[0];
               default: ;
            endcase
         end
         // Commands
         if (req_valid && req_ready) begin
            case (req_word.cmd)
               CMD_TICK: frame_tick(req_word.delta_time);
               CMD_START: begin
                  elapsed_q  = '0;
                  playing_q  = 1'b1;
                  finished_q = 1'b0;
               end
               CMD_STOP: begin
                  playing_q = 1'b0;
                  clear_vals();
               end
               CMD_LOAD_TIME: key_time_tbl[req_word.key_index] = req_word.key_time_in;
               CMD_LOAD_VALUE:
                  if (req_word.channel_select < NC)
                     key_val_tbl[req_word.key_index][req_word.channel_select] =
                        req_word.key_value_in;
               default: ;
            endcase
         end
      end
      words_pending = channel_words_due.size();
   end

endmodule

// ----- dv/keyframe_channel_interpolator_test.sv -----
// ----------------------------------------------------------------------------
// keyframe_channel_interpolator_test
// Drives commands and register writes into the interpolator with random
// gaps and rsp stalls: directed corner cases, then phases of playback over a
// random two-key table under varied poll, count and rest-phase settings.
// The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module keyframe_channel_interpolator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import kci_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;
   int           fail_count;
   int           words_pending;

   bit quiet;
   int keys_loaded;
   int ticks_sent, loads_sent, regs_written;

   keyframe_channel_interpolator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   keyframe_channel_interpolator_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .words_pending(words_pending)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   initial begin
      #40_000_000;
      $display("keyframe_channel_interpolator test failed");
      $finish;
   end

   // rsp side: random stall before each word
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic req_word_type random_word(logic [2:0] cmd);
      req_word_type w;
      w.cmd            = cmd;
      w.delta_time     = 20'($urandom);
      w.key_index      = 8'($urandom);
      w.channel_select = 5'($urandom);
      w.key_time_in    = $urandom;
      w.key_value_in   = 16'($urandom);
      return w;
   endfunction

   task automatic push_word(req_word_type w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (w.cmd == CMD_TICK) ticks_sent++;
      if (w.cmd == CMD_LOAD_TIME || w.cmd == CMD_LOAD_VALUE) loads_sent++;
   endtask

   task automatic push_cmd(logic [2:0] cmd);
      push_word(random_word(cmd));
   endtask

   task automatic push_tick(logic [19:0] dt);
      req_word_type w;
      w = random_word(CMD_TICK);
      w.delta_time = dt;
      push_word(w);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] d);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      regs_written++;
   endtask

   // Release both channels and wait until every tick has been answered
   task automatic drain(int settle);
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_value(int ch, bit jaw_low);
      if (ch == JAW_CH && jaw_low) return 16'($urandom_range(0, 200)) - 16'sd100;
      case ($urandom_range(0, 6))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return 16'($urandom_range(150, 260));
         default: return 16'($urandom);
      endcase
   endfunction

   // Full keyframe: its time and every channel value
   task automatic load_key(int k, logic [31:0] t, bit jaw_low);
      req_word_type w;
      w = random_word(CMD_LOAD_TIME);
      w.key_index   = 8'(k);
      w.key_time_in = t;
      push_word(w);
      for (int ch = 0; ch < KCI_NUM_CHANNELS; ch++) begin
         w = random_word(CMD_LOAD_VALUE);
         w.key_index      = 8'(k);
         w.channel_select = 5'(ch);
         w.key_value_in   = pick_value(ch, jaw_low);
         push_word(w);
      end
   endtask

   task automatic load_table(int n, bit ordered, output logic [31:0] span);
      logic [31:0] t, t_first;
      t = $urandom_range(0, 40000);
      t_first = t;
      for (int k = 0; k < n; k++) begin
         load_key(k, t, 1'($urandom_range(0, 1)));
         span = t - t_first;
         if (ordered) t = t + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 80000));
         else t = $urandom_range(0, 200000);
      end
      if (!ordered) span = 200000;
      if (n > keys_loaded) keys_loaded = n;
   endtask

   // Random noise: unused codes and loads that may land anywhere
   task automatic push_noise();
      case ($urandom_range(0, 2))
         0: push_cmd(3'($urandom_range(5, 7)));
         1: push_cmd(CMD_LOAD_VALUE);
         default: push_cmd(CMD_LOAD_TIME);
      endcase
   endtask

   initial begin
      int n, n_ticks, r;
      logic [31:0] span;
      logic [31:0] poll_pick;
      req_word_type w;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POLL_INTERVAL;
      csr_data  = '0;
      quiet = 0;
      keys_loaded = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle ticks, unused codes, empty table, out-of-range channel
      push_tick(20'd0);
      push_tick(20'hFFFFF);
      push_cmd(3'd5);
      push_cmd(3'd6);
      push_cmd(3'd7);
      w = random_word(CMD_LOAD_VALUE);
      w.channel_select = 5'd31;
      push_word(w);
      push_cmd(CMD_STOP);
      push_cmd(CMD_START);
      push_tick(20'd100);
      push_cmd(CMD_STOP);
      push_tick(20'd1);
      drain(20);

      // Directed: one-keyframe table near the top of the time range
      load_key(0, 32'hFFFF_F000, 1'b0);
      keys_loaded = 1;
      drain(20);
      write_reg(CSR_KEYFRAME_COUNT, 32'd1);
      write_reg(CSR_POLL_INTERVAL, 32'd0);
      push_cmd(CMD_START);
      push_tick(20'd5000);
      push_tick(20'hFFFFF);
      push_cmd(CMD_STOP);
      push_tick(20'd0);
      drain(20);

      // Random playback phases over one two-key table
      load_table(2, $urandom_range(0, 3) != 0, span);
      drain(20);
      for (int p = 0; p < 4; p++) begin
         quiet = (p == 3);
         n = $urandom_range(1, 2);
         case ($urandom_range(0, 4))
            0: poll_pick = 32'd0;
            1: poll_pick = 32'hFFFF_FFFF;
            2: poll_pick = POLL_RESET;
            default: poll_pick = $urandom_range(1, 200000);
         endcase
         write_reg(CSR_POLL_INTERVAL, poll_pick);
         write_reg(CSR_KEYFRAME_COUNT, n);
         case (p % 3)
            0: write_reg(CSR_SPEECH_END_TIME, $urandom_range(0, span + 1));
            1: write_reg(CSR_SPEECH_END_TIME, (p == 1) ? 32'hFFFF_FFFF : 32'd0);
            default: write_reg(CSR_SPEECH_END_TIME, $urandom);
         endcase
         write_reg(CSR_SPEECH_END_VALID, 32'((p % 4) != 3));
         push_cmd(CMD_START);
         n_ticks = $urandom_range(8, 12);
         for (int i = 0; i < n_ticks; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) push_noise();
            else if (r == 1) begin
               push_cmd(CMD_STOP);
               push_tick(20'($urandom_range(0, 30000)));
               push_cmd(CMD_START);
            end else if (r == 2) push_tick(20'($urandom));
            else push_tick(20'($urandom_range(0, 30000)));
         end
         drain(20);
      end
      quiet = 0;

      // Large counts, never played: the table is only partly loaded
      write_reg(CSR_KEYFRAME_COUNT, KCI_MAX_KEYS);
      push_cmd(CMD_STOP);
      push_tick(20'($urandom));
      push_tick(20'($urandom));
      drain(20);
      write_reg(CSR_KEYFRAME_COUNT, 32'h1FF);
      push_tick(20'($urandom));
      drain(20);

      // Back to a small playable table
      write_reg(CSR_KEYFRAME_COUNT, 32'd2 > keys_loaded ? keys_loaded : 32'd2);
      write_reg(CSR_SPEECH_END_VALID, 32'd0);
      write_reg(CSR_POLL_INTERVAL, 32'd0);
      push_cmd(CMD_START);
      for (int i = 0; i < 12; i++) push_tick(20'($urandom_range(0, 40000)));
      drain(1000);

      $display("Run covered %0d ticks, %0d load words and %0d register writes,",
               ticks_sent, loads_sent, regs_written);
      $display("including idle, playback, rest phase and out-of-range load cases.");
      if (fail_count == 0) begin
         $display("keyframe_channel_interpolator test passed");
      end else begin
         $display("keyframe_channel_interpolator test failed");
      end
      $finish;
   end

endmodule

// ----- keyframe_channel_interpolator.f -----
rtl/kci_pkg.sv
rtl/kci_ram.sv
rtl/kci_ctrl.sv
rtl/kci_dp.sv
rtl/keyframe_channel_interpolator.sv
dv/keyframe_channel_interpolator_checker.sv
dv/keyframe_channel_interpolator_test.sv
